### rtl/fixed_step_scheduler_with_timed_queue_defines.svh
// Assertion macros shared by the fixed-step scheduler RTL.
`ifndef FIXED_STEP_SCHEDULER_WITH_TIMED_QUEUE_DEFINES_SVH
`define FIXED_STEP_SCHEDULER_WITH_TIMED_QUEUE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FSSQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FSSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fssq_pkg.sv
// Types, codes and constants of the fixed-step scheduler with timed queue.
package fssq_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;

  localparam int ACC_W     = 26;
  localparam int TICK_W    = 64;
  localparam int SUB_W     = 8;
  localparam int ID_W      = 8;
  localparam int STEPS_W   = 12;
  localparam int PERIOD_W  = 16;
  localparam int SPT_W     = 8;
  localparam int ELAPSED_W = 24;
  localparam int KIND_W    = 3;
  localparam int OP_W      = 2;
  localparam int DIV_STEPS = ACC_W;
  localparam int DIVCNT_W  = $clog2(DIV_STEPS);

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [PERIOD_W-1:0]  PERIOD_RST   = 16'd10000;
  localparam logic [SPT_W-1:0]     SPT_RST      = 8'd4;
  localparam logic [STEPS_W-1:0]   CATCHUP_RST  = 12'd25;
  localparam logic [ELAPSED_W-1:0] ELAPSED_RST  = 24'd250000;
  localparam logic [ACC_W-1:0]     ACC_MAX      = {ACC_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_SCHEDULE = 2'd0,
    OP_ADVANCE  = 2'd1,
    OP_STEP     = 2'd2
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_RELEASED  = 3'd0,
    KIND_STEP      = 3'd1,
    KIND_ADVANCE   = 3'd2,
    KIND_SCHEDULED = 3'd3,
    KIND_FULL      = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    REG_PERIOD  = 2'd0,
    REG_SPT     = 2'd1,
    REG_CATCHUP = 2'd2,
    REG_ELAPSED = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic [SUB_W-1:0]  sub;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    kind_e              kind;
    logic [ID_W-1:0]    id;
    logic [TICK_W-1:0]  tick;
    logic [SUB_W-1:0]   sub;
    logic [STEPS_W-1:0] processed;
    logic               last;
  } result_t;

  function automatic result_t make_result(kind_e kind, logic [ID_W-1:0] id,
                                          logic [TICK_W-1:0] tick, logic [SUB_W-1:0] sub,
                                          logic [STEPS_W-1:0] processed, logic last);
    result_t r;
    r.kind      = kind;
    r.id        = id;
    r.tick      = tick;
    r.sub       = sub;
    r.processed = processed;
    r.last      = last;
    return r;
  endfunction

endpackage

### rtl/fixed_step_scheduler_with_timed_queue.sv
// Fixed-timestep pacer with a queue of timed command handles, top level.
// Advance gives no result; a schedule into a queue that is not full runs 26 divider steps.
// A performed step reads and checks each queued entry in turn; a refused step that needs
// the catch-up modulo runs it on the same shared restoring divider.
// Each result waits in the output register until its transfer; the queue memory has one
// read and one write port and is read one entry at a time. Reset empties the queue at once.
`include "fixed_step_scheduler_with_timed_queue_defines.svh"

module fixed_step_scheduler_with_timed_queue #(
  parameter int QUEUE_DEPTH = fssq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [fssq_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [fssq_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [fssq_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,

  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [fssq_pkg::OP_W-1:0]            operation_i,
  input  logic signed [fssq_pkg::ELAPSED_W-1:0] elapsed_time_i,
  input  logic [fssq_pkg::SUB_W-1:0]           subtick_offset_i,
  input  logic [fssq_pkg::ID_W-1:0]            command_id_i,

  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [fssq_pkg::KIND_W-1:0]          kind_o,
  output logic [fssq_pkg::ID_W-1:0]            released_id_o,
  output logic [fssq_pkg::TICK_W-1:0]          step_tick_o,
  output logic [fssq_pkg::SUB_W-1:0]           step_subtick_o,
  output logic [fssq_pkg::STEPS_W-1:0]         processed_o,
  output logic                                 last_o
);
  import fssq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCHED_DIV,
    S_SCHED_WR,
    S_FULL,
    S_MOD_DIV,
    S_REPORT,
    S_STEP_RD,
    S_STEP_CHK
  } state_e;

  state_e state_q;
  logic   rec_pending_q;

  logic [PERIOD_W-1:0]  period_q;
  logic [SPT_W-1:0]     spt_q;
  logic [STEPS_W-1:0]   catchup_q;
  logic [ELAPSED_W-1:0] max_elapsed_q;

  logic [ACC_W-1:0]   acc_q;
  logic [TICK_W-1:0]  tick_q;
  logic [SUB_W-1:0]   sub_q;
  logic [STEPS_W-1:0] steps_q;
  logic [CW-1:0]      count_q;
  logic [CW-1:0]      idx_q;
  logic [CW-1:0]      wr_q;
  logic [ID_W-1:0]    cmd_q;

  logic [ACC_W-1:0]    div_dq_q;
  logic [PERIOD_W-1:0] div_rem_q;
  logic [PERIOD_W-1:0] div_q;
  logic [DIVCNT_W-1:0] div_cnt_q;

  result_t out_q;
  logic    out_valid_q;

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;
  logic   mem_we;
  logic [IW-1:0] mem_waddr;
  entry_t mem_wdata;

  logic cfg_we;
  logic out_free;
  logic [PERIOD_W-1:0] eff_period;
  logic [SPT_W-1:0]    eff_spt;
  logic [PERIOD_W:0]   div_try;
  logic                div_ge;
  logic [PERIOD_W-1:0] div_rem_nx;
  logic [ACC_W-1:0]    div_dq_nx;
  logic                div_last;
  logic [SUB_W:0]      abs_sub;
  logic [ELAPSED_W-1:0] elapsed_clamped;
  logic [ACC_W:0]      acc_sum;
  logic                can_step;
  logic                catchup_cut;
  logic                due;
  logic                wrap_tick;
  logic                scan_end;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q      <= PERIOD_RST;
      spt_q         <= SPT_RST;
      catchup_q     <= CATCHUP_RST;
      max_elapsed_q <= ELAPSED_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(paddr[3:2]))
        REG_PERIOD:  period_q      <= pwdata[PERIOD_W-1:0];
        REG_SPT:     spt_q         <= pwdata[SPT_W-1:0];
        REG_CATCHUP: catchup_q     <= pwdata[STEPS_W-1:0];
        REG_ELAPSED: max_elapsed_q <= pwdata[ELAPSED_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_e'(paddr[3:2]))
      REG_PERIOD:  prdata = APB_DATA_W'(period_q);
      REG_SPT:     prdata = APB_DATA_W'(spt_q);
      REG_CATCHUP: prdata = APB_DATA_W'(catchup_q);
      REG_ELAPSED: prdata = APB_DATA_W'(max_elapsed_q);
    endcase
  end

  assign eff_period = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign eff_spt    = (spt_q == '0) ? SPT_W'(1) : spt_q;

  assign div_try    = {div_rem_q, div_dq_q[ACC_W-1]};
  assign div_ge     = div_try >= {1'b0, div_q};
  assign div_rem_nx = div_ge ? PERIOD_W'(div_try - {1'b0, div_q}) : div_try[PERIOD_W-1:0];
  assign div_dq_nx  = {div_dq_q[ACC_W-2:0], div_ge};
  assign div_last   = div_cnt_q == DIVCNT_W'(DIV_STEPS - 1);

  assign abs_sub = {1'b0, sub_q} + {1'b0, subtick_offset_i};

  always_comb begin
    if (elapsed_time_i[ELAPSED_W-1]) begin
      elapsed_clamped = '0;
    end else if (elapsed_time_i > $signed({1'b0, max_elapsed_q})) begin
      elapsed_clamped = max_elapsed_q;
    end else begin
      elapsed_clamped = elapsed_time_i;
    end
  end
  assign acc_sum = {1'b0, acc_q} + (ACC_W + 1)'(elapsed_clamped);

  assign can_step    = (acc_q >= ACC_W'(eff_period)) && (steps_q < catchup_q);
  assign catchup_cut = (steps_q >= catchup_q) && (acc_q >= ACC_W'(eff_period));
  assign due         = (rd_q.tick < tick_q) || ((rd_q.tick == tick_q) && (rd_q.sub <= sub_q));
  assign wrap_tick   = ({1'b0, sub_q} + 1'b1) >= {1'b0, eff_spt};
  assign scan_end    = (idx_q + 1'b1) == count_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    mem_we         = 1'b0;
    mem_waddr      = wr_q[IW-1:0];
    mem_wdata      = rd_q;
    if (state_q == S_SCHED_WR && out_free) begin
      mem_we         = 1'b1;
      mem_waddr      = count_q[IW-1:0];
      mem_wdata.tick = tick_q + TICK_W'(div_dq_q);
      mem_wdata.sub  = div_rem_q[SUB_W-1:0];
      mem_wdata.id   = cmd_q;
    end else if (state_q == S_STEP_CHK && !rec_pending_q && !due) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[idx_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      rec_pending_q <= 1'b0;
      acc_q         <= '0;
      tick_q        <= '0;
      sub_q         <= '0;
      steps_q       <= '0;
      count_q       <= '0;
      idx_q         <= '0;
      wr_q          <= '0;
      cmd_q         <= '0;
      div_dq_q      <= '0;
      div_rem_q     <= '0;
      div_q         <= '0;
      div_cnt_q     <= '0;
      out_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (op_e'(operation_i))
              OP_SCHEDULE: begin
                cmd_q <= command_id_i;
                if (count_q == DEPTH_C) begin
                  state_q <= S_FULL;
                end else begin
                  div_dq_q  <= ACC_W'(abs_sub);
                  div_rem_q <= '0;
                  div_q     <= PERIOD_W'(eff_spt);
                  div_cnt_q <= '0;
                  state_q   <= S_SCHED_DIV;
                end
              end
              OP_ADVANCE: begin
                acc_q   <= acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
                steps_q <= '0;
              end
              OP_STEP: begin
                if (can_step) begin
                  idx_q <= '0;
                  wr_q  <= '0;
                  if (count_q == '0) begin
                    rec_pending_q <= 1'b1;
                    state_q       <= S_STEP_CHK;
                  end else begin
                    state_q <= S_STEP_RD;
                  end
                end else if (catchup_cut) begin
                  div_dq_q  <= acc_q;
                  div_rem_q <= '0;
                  div_q     <= eff_period;
                  div_cnt_q <= '0;
                  state_q   <= S_MOD_DIV;
                end else begin
                  state_q <= S_REPORT;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCHED_DIV, S_MOD_DIV: begin
          div_dq_q  <= div_dq_nx;
          div_rem_q <= div_rem_nx;
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_last) begin
            if (state_q == S_MOD_DIV) begin
              acc_q   <= ACC_W'(div_rem_nx);
              state_q <= S_REPORT;
            end else begin
              state_q <= S_SCHED_WR;
            end
          end
        end
        S_SCHED_WR: begin
          if (out_free) begin
            count_q     <= count_q + 1'b1;
            out_q       <= make_result(KIND_SCHEDULED, '0, tick_q, sub_q, '0, 1'b1);
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_FULL: begin
          if (out_free) begin
            out_q       <= make_result(KIND_FULL, '0, tick_q, sub_q, '0, 1'b1);
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_REPORT: begin
          if (out_free) begin
            out_q       <= make_result(KIND_ADVANCE, '0, tick_q, sub_q, steps_q, 1'b1);
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_STEP_RD: begin
          state_q <= S_STEP_CHK;
        end
        S_STEP_CHK: begin
          if (rec_pending_q) begin
            if (out_free) begin
              out_q         <= make_result(KIND_STEP, '0, tick_q, sub_q, '0, 1'b1);
              out_valid_q   <= 1'b1;
              rec_pending_q <= 1'b0;
              count_q       <= wr_q;
              acc_q         <= acc_q - ACC_W'(eff_period);
              steps_q       <= steps_q + 1'b1;
              if (wrap_tick) begin
                sub_q  <= '0;
                tick_q <= tick_q + 1'b1;
              end else begin
                sub_q <= sub_q + 1'b1;
              end
              state_q <= S_IDLE;
            end
          end else if (!due || out_free) begin
            if (due) begin
              out_q       <= make_result(KIND_RELEASED, rd_q.id, tick_q, sub_q, '0, 1'b0);
              out_valid_q <= 1'b1;
            end else begin
              wr_q <= wr_q + 1'b1;
            end
            idx_q <= idx_q + 1'b1;
            if (scan_end) begin
              rec_pending_q <= 1'b1;
            end else begin
              state_q <= S_STEP_RD;
            end
          end
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign released_id_o  = out_q.id;
  assign step_tick_o    = out_q.tick;
  assign step_subtick_o = out_q.sub;
  assign processed_o    = out_q.processed;
  assign last_o         = out_q.last;

  `FSSQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= DEPTH_C, "queue count beyond depth")
  `FSSQ_ASSERT_NOW(a_scan_order, state_q == S_STEP_CHK && !rec_pending_q,
    wr_q <= idx_q && idx_q < count_q, "queue scan out of order")
  `FSSQ_ASSERT_NOW(a_only_release_open, out_valid_o && !last_o,
    kind_o == KIND_RELEASED, "only a released command may precede more results")
  `FSSQ_ASSERT_NEXT(a_sched_grows, state_q == S_SCHED_WR && out_free,
    count_q == $past(count_q) + 1'b1, "scheduled command not added to queue")

endmodule

### test/tb_fixed_step_scheduler_with_timed_queue.sv
// Self-checking testbench for the fixed-step scheduler with timed queue.
module tb_fixed_step_scheduler_with_timed_queue;
  import fssq_pkg::*;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [ELAPSED_W-1:0] elapsed;
    logic [SUB_W-1:0]     offset;
    logic [ID_W-1:0]      id;
    logic                 typed;
    result_t              want;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;
  localparam result_t SCHED_AT_ZERO = '{KIND_SCHEDULED, 8'h00, 64'd0, 8'h00, 12'h000, 1'b1};
  localparam result_t REFUSED_AT_ZERO = '{KIND_ADVANCE, 8'h00, 64'd0, 8'h00, 12'h000, 1'b1};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OP_W-1:0] operation_i = '0;
  logic signed [ELAPSED_W-1:0] elapsed_time_i = '0;
  logic [SUB_W-1:0] subtick_offset_i = '0;
  logic [ID_W-1:0] command_id_i = '0;

  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [KIND_W-1:0] kind_o;
  logic [ID_W-1:0] released_id_o;
  logic [TICK_W-1:0] step_tick_o;
  logic [SUB_W-1:0] step_subtick_o;
  logic [STEPS_W-1:0] processed_o;
  logic last_o;

  logic [PERIOD_W-1:0]  cfg_period = PERIOD_RST;
  logic [SPT_W-1:0]     cfg_spt = SPT_RST;
  logic [STEPS_W-1:0]   cfg_catchup = CATCHUP_RST;
  logic [ELAPSED_W-1:0] cfg_max_elapsed = ELAPSED_RST;

  logic [ACC_W-1:0]   pace_acc = '0;
  logic [TICK_W-1:0]  pace_tick = '0;
  logic [SUB_W-1:0]   pace_sub = '0;
  logic [STEPS_W-1:0] pace_steps = '0;
  entry_t  timed_cmds[$];
  result_t awaited[$];

  bit calm = 1'b0;
  int rx_hold_left = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int release_count = 0;
  int full_count = 0;
  int cut_count = 0;
  int settings_used = 0;

  stim_row_t dir_tab [16] = '{
    '{OP_STEP,     24'h000000, 8'h00, 8'h00, 1'b1, REFUSED_AT_ZERO},
    '{OP_SCHEDULE, 24'h000000, 8'h00, 8'hA5, 1'b1, SCHED_AT_ZERO},
    '{OP_SCHEDULE, 24'hFFFFFF, 8'hFF, 8'h00, 1'b1, SCHED_AT_ZERO},
    '{OP_SCHEDULE, 24'h000000, 8'h01, 8'hFF, 1'b1, SCHED_AT_ZERO},
    '{OP_NONE,     24'h5A5A5A, 8'hFF, 8'hFF, 1'b0, NO_RESULT},
    '{OP_ADVANCE,  24'h800000, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{OP_STEP,     24'h000000, 8'h00, 8'h00, 1'b1, REFUSED_AT_ZERO},
    '{OP_ADVANCE,  24'h7FFFFF, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{OP_STEP,     24'h000000, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{OP_STEP,     24'h000000, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{OP_STEP,     24'h000000, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{OP_SCHEDULE, 24'h000000, 8'h00, 8'h3C, 1'b0, NO_RESULT},
    '{OP_STEP,     24'h000000, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{OP_ADVANCE,  24'h000000, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{OP_STEP,     24'h000000, 8'h00, 8'h00, 1'b0, NO_RESULT},
    '{OP_STEP,     24'h000000, 8'h00, 8'h00, 1'b0, NO_RESULT}
  };

  fixed_step_scheduler_with_timed_queue dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void add_result(kind_e kind, logic [ID_W-1:0] id,
                                     logic [STEPS_W-1:0] processed, logic last);
    result_t r;
    r.kind      = kind;
    r.id        = id;
    r.tick      = pace_tick;
    r.sub       = pace_sub;
    r.processed = processed;
    r.last      = last;
    awaited = {awaited, r};
  endfunction

  function automatic void predict_pacer(logic [OP_W-1:0] op, logic [ELAPSED_W-1:0] elapsed,
                                        logic [SUB_W-1:0] offset, logic [ID_W-1:0] id);
    int unsigned per;
    int unsigned spt;
    int unsigned whole;
    logic [ELAPSED_W-1:0] added;
    logic [ACC_W:0] sum;
    entry_t cmd;
    entry_t kept[$];
    per = (cfg_period == 0) ? 1 : cfg_period;
    spt = (cfg_spt == 0) ? 1 : cfg_spt;
    case (op)
      OP_SCHEDULE: begin
        if (timed_cmds.size() >= DEPTH) begin
          add_result(KIND_FULL, '0, '0, 1'b1);
          full_count++;
        end else begin
          whole = pace_sub + offset;
          cmd.tick = pace_tick + whole / spt;
          cmd.sub  = SUB_W'(whole % spt);
          cmd.id   = id;
          timed_cmds = {timed_cmds, cmd};
          add_result(KIND_SCHEDULED, '0, '0, 1'b1);
        end
      end
      OP_ADVANCE: begin
        added = elapsed[ELAPSED_W-1] ? '0 :
                (elapsed > cfg_max_elapsed) ? cfg_max_elapsed : elapsed;
        sum = pace_acc + added;
        pace_acc = (sum > ACC_MAX) ? ACC_MAX : sum[ACC_W-1:0];
        pace_steps = '0;
      end
      OP_STEP: begin
        if (pace_acc >= per && pace_steps < cfg_catchup) begin
          foreach (timed_cmds[i]) begin
            if (timed_cmds[i].tick < pace_tick ||
                (timed_cmds[i].tick == pace_tick && timed_cmds[i].sub <= pace_sub)) begin
              add_result(KIND_RELEASED, timed_cmds[i].id, '0, 1'b0);
              release_count++;
            end else begin
              kept = {kept, timed_cmds[i]};
            end
          end
          timed_cmds = kept;
          add_result(KIND_STEP, '0, '0, 1'b1);
          pace_acc = ACC_W'(pace_acc - per);
          pace_steps = pace_steps + 1'b1;
          if (pace_sub + 1 >= spt) begin
            pace_sub = '0;
            pace_tick = pace_tick + 1'b1;
          end else begin
            pace_sub = pace_sub + 1'b1;
          end
        end else begin
          if (pace_steps >= cfg_catchup && pace_acc >= per) begin
            pace_acc = ACC_W'(pace_acc % per);
            cut_count++;
          end
          add_result(KIND_ADVANCE, '0, pace_steps, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [TICK_W-1:0] got, logic [TICK_W-1:0] want);
    $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (awaited.size() == 0) begin
        report_mismatch("result transfer with nothing awaited, kind", kind_o, '0);
      end else begin
        want = awaited.pop_front();
        if (kind_o !== want.kind) report_mismatch("kind", kind_o, want.kind);
        if (released_id_o !== want.id) report_mismatch("released_id", released_id_o, want.id);
        if (step_tick_o !== want.tick) report_mismatch("step_tick", step_tick_o, want.tick);
        if (step_subtick_o !== want.sub) report_mismatch("step_subtick", step_subtick_o, want.sub);
        if (processed_o !== want.processed) begin
          report_mismatch("processed", processed_o, want.processed);
        end
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_stall_i = 1'b1;
        rx_hold_left--;
      end else begin
        out_stall_i = !calm && ($urandom_range(99) < 21);
      end
    end
  end

  task automatic send_item(input stim_row_t row);
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < 21) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    operation_i      = row.op;
    elapsed_time_i   = row.elapsed;
    subtick_offset_i = row.offset;
    command_id_i     = row.id;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    predict_pacer(row.op, row.elapsed, row.offset, row.id);
    if (row.typed) awaited[awaited.size()-1] = row.want;
  endtask

  function automatic stim_row_t random_row();
    stim_row_t row;
    int unsigned pick;
    int unsigned per;
    row = '0;
    pick = $urandom_range(99);
    per = (cfg_period == 0) ? 1 : cfg_period;
    row.op = (pick < 30) ? OP_SCHEDULE : (pick < 45) ? OP_ADVANCE :
             (pick < 95) ? OP_STEP : OP_NONE;
    row.elapsed = ELAPSED_W'($urandom);
    if ($urandom_range(9) < 6) row.elapsed = ELAPSED_W'($urandom_range(4 * per, 0));
    row.offset = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7, 0));
    row.id = ID_W'($urandom);
    return row;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_item(random_row());
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(cfg_reg_e idx, logic [APB_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_PERIOD:  cfg_period = value[PERIOD_W-1:0];
      REG_SPT:     cfg_spt = value[SPT_W-1:0];
      REG_CATCHUP: cfg_catchup = value[STEPS_W-1:0];
      REG_ELAPSED: cfg_max_elapsed = value[ELAPSED_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(int unsigned period, int unsigned spt, int unsigned catchup,
                           int unsigned max_elapsed);
    apb_write(REG_PERIOD, period);
    apb_write(REG_SPT, spt);
    apb_write(REG_CATCHUP, catchup);
    apb_write(REG_ELAPSED, max_elapsed);
    settings_used++;
  endtask

  initial begin
    stim_row_t row;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) send_item(dir_tab[i]);

    // The receiver holds off while schedules keep coming, so the queue and the block fill up.
    rx_hold_left = HOLD_CYCLES;
    calm = 1'b1;
    repeat (34) begin
      row = random_row();
      row.op = OP_SCHEDULE;
      row.offset = SUB_W'($urandom_range(15, 0));
      send_item(row);
    end
    calm = 1'b0;
    run_random(30);
    settle();

    configure(1, 1, 1, 0);
    calm = 1'b1;
    run_random(15);
    calm = 1'b0;
    settle();

    configure(16'hFFFF, 255, 4095, 24'hFFFFFF);
    run_random(30);
    settle();

    configure(0, 3, 3, 50);
    run_random(30);
    settle();

    configure(2500, 0, 0, 24'hFFFFFF);
    calm = 1'b1;
    run_random(15);
    calm = 1'b0;
    settle();

    configure(1000, 8, 6, 20000);
    run_random(40);
    settle();

    $display("Run moved %0d input transfers and %0d result transfers: %0d releases,",
             items_sent, results_seen, release_count);
    $display("%0d queue-full replies and %0d catch-up cuts over %0d register settings.",
             full_count, cut_count, settings_used);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("tb_fixed_step_scheduler_with_timed_queue passed");
    end else begin
      $display("tb_fixed_step_scheduler_with_timed_queue failed");
    end
    $finish;
  end

  initial begin
    #4800000;
    $display("tb_fixed_step_scheduler_with_timed_queue failed");
    $finish;
  end

endmodule
